>>> hw/rtl/spf_pkg.sv
// spf_pkg: shared types and constants of the serial packet framer
// frame byte codes, item kinds and the run request passed to the serialiser
// no dependencies
package spf_pkg;

  // frame bytes
  localparam logic [7:0] FRAME_MARK = 8'h81;
  localparam logic [7:0] FRAME_TAIL = 8'h00;

  // item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // channel code with no serial port behind it
  localparam logic [1:0] PORT_NONE = 2'd3;

  // bytes per run
  localparam int HDR_BYTES = 6;
  localparam int TRL_BYTES = 4;
  localparam int MAX_RUN   = HDR_BYTES + TRL_BYTES;
  localparam int CNT_W     = $clog2(MAX_RUN + 1);
  localparam int IDX_W     = $clog2(MAX_RUN);

  // one run of bytes caused by a single item
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    pkt_end;
    logic [1:0]              port;
  } run_t;

endpackage

>>> hw/rtl/spf_packer.sv
// spf_packer: input register, packet state and run builder of the framer
// turns each item into the run of bytes it causes; hands runs to spf_serializer
// depends on spf_pkg
module spf_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          own_address,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [1:0]          channel,
  input  logic [7:0]          receiver,
  input  logic [7:0]          opcode,
  input  logic [15:0]         payload_length,
  input  logic [7:0]          data_byte,
  input  logic                sink_ready,
  output logic                run_load,
  output spf_pkg::run_t       run_req
);

  // input register
  logic        a_valid;
  logic        a_kind;
  logic [1:0]  a_channel;
  logic [7:0]  a_receiver;
  logic [7:0]  a_opcode;
  logic [15:0] a_len;
  logic [7:0]  a_data;

  // packet state
  logic        packet_open;
  logic [15:0] bytes_remaining;
  logic [15:0] running_sum;
  logic [1:0]  open_port;

  logic        packet_open_next;
  logic [15:0] bytes_remaining_next;
  logic [15:0] running_sum_next;
  logic [1:0]  open_port_next;

  logic        a_move;
  logic [15:0] len_plus1;
  logic [15:0] sum_hdr;
  logic [15:0] sum_dat;
  logic [15:0] rem_dat;

  // item leaves the input register when it causes nothing or the serialiser is free
  assign a_move   = a_valid && (run_req.count == '0 || sink_ready);
  assign run_load = a_move && run_req.count != '0;
  assign in_stall = a_valid && !a_move;

  assign len_plus1 = a_len + 16'd1;
  assign sum_hdr   = 16'(a_receiver) + 16'(a_len[7:0]) + 16'(a_len[15:8])
                   + 16'(a_opcode) + 16'(own_address) + 16'd1;
  assign sum_dat   = running_sum + 16'(a_data);
  assign rem_dat   = bytes_remaining - 16'd1;

  // run builder and next packet state
  always_comb begin
    run_req              = '0;
    packet_open_next     = packet_open;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    open_port_next       = open_port;
    if (a_kind == spf_pkg::KIND_HEADER) begin
      packet_open_next = 1'b0;
      if (a_channel != spf_pkg::PORT_NONE) begin
        open_port_next       = a_channel;
        running_sum_next     = sum_hdr;
        bytes_remaining_next = a_len;
        packet_open_next     = 1'b1;
        run_req.port         = a_channel;
        run_req.bytes[0]     = spf_pkg::FRAME_MARK;
        run_req.bytes[1]     = a_receiver;
        run_req.bytes[2]     = own_address;
        run_req.bytes[3]     = len_plus1[7:0];
        run_req.bytes[4]     = len_plus1[15:8];
        run_req.bytes[5]     = a_opcode;
        run_req.count        = spf_pkg::CNT_W'(spf_pkg::HDR_BYTES);
        // empty payload: trailer follows straight away
        if (a_len == 16'd0) begin
          packet_open_next = 1'b0;
          run_req.bytes[6] = sum_hdr[7:0];
          run_req.bytes[7] = sum_hdr[15:8];
          run_req.bytes[8] = spf_pkg::FRAME_MARK;
          run_req.bytes[9] = spf_pkg::FRAME_TAIL;
          run_req.count    = spf_pkg::CNT_W'(spf_pkg::MAX_RUN);
          run_req.pkt_end  = 1'b1;
        end
      end
    end else if (packet_open) begin
      running_sum_next     = sum_dat;
      bytes_remaining_next = rem_dat;
      run_req.port         = open_port;
      run_req.bytes[0]     = a_data;
      run_req.count        = spf_pkg::CNT_W'(1);
      // last payload byte closes the packet
      if (rem_dat == 16'd0) begin
        packet_open_next = 1'b0;
        run_req.bytes[1] = sum_dat[7:0];
        run_req.bytes[2] = sum_dat[15:8];
        run_req.bytes[3] = spf_pkg::FRAME_MARK;
        run_req.bytes[4] = spf_pkg::FRAME_TAIL;
        run_req.count    = spf_pkg::CNT_W'(1 + spf_pkg::TRL_BYTES);
        run_req.pkt_end  = 1'b1;
      end
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_kind     <= kind;
      a_channel  <= channel;
      a_receiver <= receiver;
      a_opcode   <= opcode;
      a_len      <= payload_length;
      a_data     <= data_byte;
    end
  end

  // packet state update
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open     <= 1'b0;
      bytes_remaining <= 16'd0;
      running_sum     <= 16'd0;
      open_port       <= 2'd0;
    end else if (a_move) begin
      packet_open     <= packet_open_next;
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
      open_port       <= open_port_next;
    end
  end

endmodule

>>> hw/rtl/spf_serializer.sv
// spf_serializer: run register that sends one byte of the current run per cycle while out_stall is low
// holds the run taken from spf_packer and drives the output channel
// depends on spf_pkg
module spf_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                run_load,
  input  spf_pkg::run_t       run_req,
  output logic                sink_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          port,
  output logic [7:0]          tx_byte,
  output logic                last_of_run,
  output logic                packet_end
);

  logic                       run_valid;
  spf_pkg::run_t              run;
  logic [spf_pkg::IDX_W-1:0]  run_idx;
  logic                       is_last;
  logic                       out_take;

  assign is_last    = 5'(run_idx) + 5'd1 == 5'(run.count);
  assign out_take   = run_valid && !out_stall;
  assign sink_ready = !run_valid || (out_take && is_last);

  // output fields
  assign out_valid   = run_valid;
  assign port        = run.port;
  assign tx_byte     = run.bytes[run_idx];
  assign last_of_run = is_last;
  assign packet_end  = run.pkt_end && is_last;

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx   <= '0;
    end else if (run_load) begin
      run_valid <= 1'b1;
      run_idx   <= '0;
    end else if (out_take) begin
      if (is_last) begin
        run_valid <= 1'b0;
      end else begin
        run_idx <= run_idx + spf_pkg::IDX_W'(1);
      end
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (run_load) begin
      run <= run_req;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> 5'(run_idx) < 5'(run.count))
    else $error("byte index beyond run length");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    run_load |-> (!run_valid || (out_take && is_last)))
    else $error("run loaded over an unfinished run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    run_valid && out_stall |=> run_valid && $stable(run_idx))
    else $error("byte moved on while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> last_of_run && tx_byte == spf_pkg::FRAME_TAIL)
    else $error("packet end not on closing byte");
`endif

endmodule

>>> hw/rtl/serial_packet_framer.sv
// serial_packet_framer: a request passes the input register, then the run register, before its first byte is output.
// throughput: one output byte per cycle while out_stall is low; an item loads a run of 1, 5, 6 or 10 bytes,
// sent one at a time from the run register; items causing no bytes leave without waiting for the serialiser.
// one more item waits in the input register while a run is being sent.
// reset (rst, synchronous): no packet open, sum and count zero, own_address zero,
// input and run registers empty.
module serial_packet_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [1:0]  channel,
  input  logic [7:0]  receiver,
  input  logic [7:0]  opcode,
  input  logic [15:0] payload_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  port,
  output logic [7:0]  tx_byte,
  output logic        last_of_run,
  output logic        packet_end
);

  logic [7:0]    own_addr;
  logic          sink_ready;
  logic          run_load;
  spf_pkg::run_t run_req;

  assign cfg_ready = 1'b1;

  // address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      own_addr <= cfg_data;
    end
  end

  // packet state and run builder
  spf_packer u_packer (
    .clk            (clk),
    .rst            (rst),
    .own_address    (own_addr),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .channel        (channel),
    .receiver       (receiver),
    .opcode         (opcode),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .sink_ready     (sink_ready),
    .run_load       (run_load),
    .run_req        (run_req)
  );

  // byte serialiser
  spf_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .run_load    (run_load),
    .run_req     (run_req),
    .sink_ready  (sink_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .port        (port),
    .tx_byte     (tx_byte),
    .last_of_run (last_of_run),
    .packet_end  (packet_end)
  );

endmodule

>>> sim/serial_packet_framer_tb.sv
`timescale 1ns / 1ps
// serial_packet_framer_tb: self-checking bench for the serial packet framer
// predicts every frame byte in a scoreboard class and checks the serial output
// depends on spf_pkg and serial_packet_framer
module serial_packet_framer_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        kind;
    logic [1:0]  channel;
    logic [7:0]  receiver;
    logic [7:0]  opcode;
    logic [15:0] length;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    logic [1:0] port;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic       packet_end;
  } frame_byte_t;

  // frame byte predictor and store of bytes still to come
  class framer_scoreboard;
    logic [7:0]  own_addr;
    bit          pkt_open;
    logic [15:0] left;
    logic [15:0] sum;
    logic [1:0]  open_port;
    frame_byte_t owed[$];
    int          failures;

    function new();
      own_addr = 8'h00;
      pkt_open = 1'b0;
      left = 16'h0000;
      sum = 16'h0000;
      open_port = 2'd0;
      failures = 0;
    endfunction

    function void set_address(logic [7:0] v);
      own_addr = v;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void push_byte(logic [1:0] p, logic [7:0] b, logic e);
      frame_byte_t fb;
      fb.port = p;
      fb.tx_byte = b;
      fb.last_of_run = 1'b0;
      fb.packet_end = e;
      owed.push_back(fb);
    endfunction

    // checksum, mark and closing byte
    function void push_trailer();
      push_byte(open_port, sum[7:0], 1'b0);
      push_byte(open_port, sum[15:8], 1'b0);
      push_byte(open_port, spf_pkg::FRAME_MARK, 1'b0);
      push_byte(open_port, spf_pkg::FRAME_TAIL, 1'b1);
      pkt_open = 1'b0;
    endfunction

    // work out the bytes one accepted request causes
    function void note_request(request_t r);
      int          before_cnt;
      logic [15:0] lenp1;
      before_cnt = owed.size();
      if (r.kind == spf_pkg::KIND_HEADER) begin
        pkt_open = 1'b0;
        if (r.channel != spf_pkg::PORT_NONE) begin
          open_port = r.channel;
          lenp1 = r.length + 16'd1;
          sum = r.receiver + r.length[7:0] + r.length[15:8] + r.opcode + own_addr + 16'd1;
          push_byte(r.channel, spf_pkg::FRAME_MARK, 1'b0);
          push_byte(r.channel, r.receiver, 1'b0);
          push_byte(r.channel, own_addr, 1'b0);
          push_byte(r.channel, lenp1[7:0], 1'b0);
          push_byte(r.channel, lenp1[15:8], 1'b0);
          push_byte(r.channel, r.opcode, 1'b0);
          pkt_open = 1'b1;
          left = r.length;
          if (r.length == 16'd0) push_trailer();
        end
      end else if (pkt_open) begin
        push_byte(open_port, r.data, 1'b0);
        sum = sum + r.data;
        left = left - 16'd1;
        if (left == 16'd0) push_trailer();
      end
      if (owed.size() > before_cnt) owed[owed.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_result(frame_byte_t act);
      frame_byte_t exp;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected byte: port %0d byte %02h last %0b end %0b",
                       act.port, act.tx_byte, act.last_of_run, act.packet_end));
      end else begin
        exp = owed.pop_front();
        if (act !== exp)
          flag($sformatf({"mismatch: port %0d byte %02h last %0b end %0b, ",
                          "expected port %0d byte %02h last %0b end %0b"},
                         act.port, act.tx_byte, act.last_of_run, act.packet_end,
                         exp.port, exp.tx_byte, exp.last_of_run, exp.packet_end));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [1:0]  channel = 2'd0;
  logic [7:0]  receiver = 8'h00;
  logic [7:0]  opcode = 8'h00;
  logic [15:0] payload_length = 16'h0000;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  port;
  logic [7:0]  tx_byte;
  logic        last_of_run;
  logic        packet_end;

  framer_scoreboard sb = new();
  bit hold_request = 1'b0;
  int send_calm = 0;
  int quiet_cycles = 0;

  serial_packet_framer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .channel        (channel),
    .receiver       (receiver),
    .opcode         (opcode),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .port           (port),
    .tx_byte        (tx_byte),
    .last_of_run    (last_of_run),
    .packet_end     (packet_end)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle cycles before the next request, with runs of back-to-back requests
  function automatic int sender_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_calm = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(request_t r);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    channel <= r.channel;
    receiver <= r.receiver;
    opcode <= r.opcode;
    payload_length <= r.length;
    data_byte <= r.data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  // header request, data field left as noise
  task automatic send_header(logic [1:0] ch, logic [7:0] rcv, logic [7:0] op,
                             logic [15:0] len);
    request_t r;
    r.kind = spf_pkg::KIND_HEADER;
    r.channel = ch;
    r.receiver = rcv;
    r.opcode = op;
    r.length = len;
    r.data = 8'($urandom_range(0, 255));
    send_request(r);
  endtask

  // data request, header fields left as noise
  task automatic send_data(logic [7:0] d);
    request_t r;
    r.kind = spf_pkg::KIND_DATA;
    r.channel = 2'($urandom_range(0, 3));
    r.receiver = 8'($urandom_range(0, 255));
    r.opcode = 8'($urandom_range(0, 255));
    r.length = 16'($urandom_range(0, 65535));
    r.data = d;
    send_request(r);
  endtask

  task automatic write_own_address(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_address(v);
  endtask

  // drain every owed byte, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly whole packets with random content, some cut short, some noise
  task automatic run_random_phase(int target, int hold_at);
    int sent;
    int r;
    int len;
    int cut;
    sent = 0;
    while (sent < target) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_at = -1;
        hold_request = 1'b1;
        send_calm = 40;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        send_header(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 16'(len));
        repeat (len) send_data(8'($urandom_range(0, 255)));
        sent += 1 + len;
      end else if (r < 82) begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 12) : $urandom_range(1, 65535);
        cut = $urandom_range(0, (len - 1 < 5) ? len - 1 : 5);
        send_header(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 16'(len));
        repeat (cut) send_data(8'($urandom_range(0, 255)));
        sent += 1 + cut;
      end else if (r < 90) begin
        send_header(spf_pkg::PORT_NONE, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        sent++;
      end else begin
        cut = $urandom_range(1, 2);
        repeat (cut) send_data(8'($urandom_range(0, 255)));
        sent += cut;
      end
    end
  endtask

  // receiver stalls: random bursts, calm stretches, and one long hold on request
  initial begin : rx_stall
    int stall_left;
    int mode_left;
    bit calm;
    int r;
    stall_left = 0;
    mode_left = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        stall_left = 0;
      end else begin
        if (mode_left == 0) begin
          calm = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(30, 100);
        end
        mode_left--;
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
          r = $urandom_range(0, 99);
          stall_left = (r < 75) ? $urandom_range(0, 2) :
                       (r < 95) ? $urandom_range(3, 8) : $urandom_range(15, 30);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{port: port, tx_byte: tx_byte, last_of_run: last_of_run,
                        packet_end: packet_end});
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // main sequence
  initial begin : main_seq
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: own address zero
    write_own_address(8'h00);
    send_data(8'hAB);                                // no packet open, ignored
    send_header(2'd0, 8'h00, 8'h00, 16'h0000);        // empty packet
    send_header(2'd1, 8'hFF, 8'hFF, 16'h0002);
    send_data(8'h00);
    send_data(8'hFF);
    send_header(2'd2, 8'h5A, 8'hA5, 16'hFFFF);        // longest length, then dropped
    send_data(8'h12);
    send_header(2'd0, 8'h3C, 8'hC3, 16'h0001);        // header drops the open packet
    send_data(8'h77);
    send_header(2'd2, 8'h11, 8'h22, 16'h0003);
    send_data(8'h44);
    send_header(spf_pkg::PORT_NONE, 8'hFF, 8'hFF, 16'hFFFF); // no such port, packet dropped
    send_data(8'h55);                                // nothing open any more
    settle();

    // directed: own address all ones, checksum wraps
    write_own_address(8'hFF);
    send_header(2'd1, 8'hFF, 8'hFF, 16'hFF01);
    send_header(2'd2, 8'hFF, 8'hFF, 16'h0001);
    send_data(8'hFF);
    send_header(2'd0, 8'h80, 8'h01, 16'hFFFF);        // length plus one wraps to zero
    send_header(2'd1, 8'h01, 8'h80, 16'h0000);
    settle();

    // random phases at several addresses, one with a long receiver hold
    write_own_address(8'($urandom_range(0, 255)));
    run_random_phase(40, -1);
    settle();
    write_own_address(8'h00);
    run_random_phase(40, 15);
    settle();
    write_own_address(8'($urandom_range(0, 255)));
    run_random_phase(40, -1);
    settle();

    if (sb.pending() != 0) sb.flag($sformatf("%0d bytes never arrived", sb.pending()));
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
